// File: rtl/mhpq_pkg.sv
`default_nettype none

package mhpq_pkg;

  // Width of the reported entry count; the count wraps to this width.
  localparam int unsigned COUNT_W = 7;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    FUNC_INSERT  = 1'b0,
    FUNC_EXTRACT = 1'b1
  } func_e;

endpackage

`default_nettype wire

// File: rtl/min_heap_priority_queue_top.sv
`default_nettype none

// Channel  Direction  Handshake                 Fields
// in       sink       in_valid_i / in_stall_o   func_i, key_i, payload_i
// out      source     out_valid_o / out_stall_i status_o, key_out_o, payload_out_o, count_o
//
// One item at a time. The heap lives in a single-write, dual-read memory with
// registered read data; each heap level is a read-compare-write step.
// An insert writes the entry at the tail and sifts it up; an extract reads the
// root and the tail entry and sifts the tail entry down from the root. The next
// item can be accepted in the cycle after the result is loaded.
// Reset empties the heap at once; the memory needs no clearing.
// A stalled result is held in the output register; the next item is accepted
// meanwhile and finishes once that result is taken.
module min_heap_priority_queue_top #(
  parameter int unsigned CAPACITY     = 64,
  parameter int unsigned KEY_BITS     = 32,
  parameter int unsigned PAYLOAD_BITS = 8
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire                              func_i,
  input  wire [KEY_BITS-1:0]               key_i,
  input  wire [PAYLOAD_BITS-1:0]           payload_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output mhpq_pkg::status_e                status_o,
  output logic [KEY_BITS-1:0]              key_out_o,
  output logic [PAYLOAD_BITS-1:0]          payload_out_o,
  output logic [mhpq_pkg::COUNT_W-1:0]     count_o
);

  import mhpq_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CHD_W = IDX_W + 2;

  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] pay;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CMP,
    S_DN_ROOT,
    S_DN_CMP,
    S_PLACE,
    S_DONE
  } state_e;

  state_e                  state_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [IDX_W-1:0]        pos_q;
  entry_t                  mov_q;
  status_e                 res_status_q;
  logic [KEY_BITS-1:0]     res_key_q;
  logic [PAYLOAD_BITS-1:0] res_pay_q;

  entry_t                  mem_q [CAPACITY];
  entry_t                  rd_a_q;
  entry_t                  rd_b_q;

  logic                    mem_we;
  logic [IDX_W-1:0]        mem_waddr;
  entry_t                  mem_wdata;
  logic [IDX_W-1:0]        mem_ra;
  logic [IDX_W-1:0]        mem_rb;

  entry_t                  ent_in;
  logic                    accept;
  logic                    is_full;
  logic                    is_empty;
  logic [IDX_W-1:0]        cnt_idx;
  logic [IDX_W-1:0]        tail_idx;
  logic [IDX_W-1:0]        ins_par;
  logic [IDX_W-1:0]        par;
  logic [IDX_W-1:0]        ppar;
  logic                    up_less;
  logic [CHD_W-1:0]        n_ext;
  logic [CHD_W-1:0]        l_w;
  logic [CHD_W-1:0]        r_w;
  logic                    use_r;
  entry_t                  child;
  logic [IDX_W-1:0]        c_idx;
  logic                    dn_less;
  logic [CHD_W-1:0]        cl_w;
  logic [CHD_W-1:0]        cr_w;

  assign ent_in     = '{key: key_i, pay: payload_i};
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign is_full    = (cnt_q == CNT_W'(CAPACITY));
  assign is_empty   = (cnt_q == '0);
  assign cnt_idx    = cnt_q[IDX_W-1:0];
  assign tail_idx   = IDX_W'(cnt_q - 1'b1);
  assign ins_par    = (cnt_idx - 1'b1) >> 1;
  assign par        = (pos_q - 1'b1) >> 1;
  assign ppar       = (par - 1'b1) >> 1;
  assign up_less    = (mov_q.key < rd_a_q.key);

  // Sift-down child pick: left wins a tie, right only when present.
  assign n_ext   = CHD_W'(cnt_q);
  assign l_w     = {1'b0, pos_q, 1'b1};
  assign r_w     = l_w + 1'b1;
  assign use_r   = (r_w < n_ext) && (rd_b_q.key < rd_a_q.key);
  assign child   = use_r ? rd_b_q : rd_a_q;
  assign c_idx   = use_r ? r_w[IDX_W-1:0] : l_w[IDX_W-1:0];
  assign dn_less = (child.key < mov_q.key);
  assign cl_w    = {1'b0, c_idx, 1'b1};
  assign cr_w    = cl_w + 1'b1;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos_q;
    mem_wdata = mov_q;
    mem_ra    = par;
    mem_rb    = par;
    unique case (state_q)
      S_IDLE: begin
        if (func_i == FUNC_INSERT) begin
          mem_we    = accept && !is_full;
          mem_waddr = cnt_idx;
          mem_wdata = ent_in;
          mem_ra    = ins_par;
        end else begin
          mem_ra = '0;
          mem_rb = tail_idx;
        end
      end
      S_UP_CMP: begin
        mem_we = 1'b1;
        mem_ra = ppar;
        if (up_less) begin
          mem_wdata = rd_a_q;
        end
      end
      S_DN_ROOT: begin
        mem_waddr = '0;
        mem_wdata = rd_b_q;
        mem_we    = (cnt_q == CNT_W'(1));
        mem_ra    = IDX_W'(1);
        mem_rb    = (cnt_q > CNT_W'(2)) ? IDX_W'(2) : IDX_W'(1);
      end
      S_DN_CMP: begin
        mem_we = 1'b1;
        mem_ra = cl_w[IDX_W-1:0];
        mem_rb = (cr_w < n_ext) ? cr_w[IDX_W-1:0] : cl_w[IDX_W-1:0];
        if (dn_less) begin
          mem_wdata = child;
        end
      end
      S_PLACE: begin
        mem_we = 1'b1;
      end
      S_DONE: begin
        mem_we = 1'b0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_a_q <= mem_q[mem_ra];
    rd_b_q <= mem_q[mem_rb];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cnt_q         <= '0;
      pos_q         <= '0;
      mov_q         <= '0;
      res_status_q  <= ST_OK;
      res_key_q     <= '0;
      res_pay_q     <= '0;
      out_valid_o   <= 1'b0;
      status_o      <= ST_OK;
      key_out_o     <= '0;
      payload_out_o <= '0;
      count_o       <= '0;
    end else begin
      // drop the result beat once taken
      if (out_valid_o && !out_stall_i && state_q != S_DONE) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            res_key_q    <= '0;
            res_pay_q    <= '0;
            res_status_q <= ST_OK;
            if (func_i == FUNC_INSERT) begin
              if (is_full) begin
                res_status_q <= ST_FULL;
                state_q      <= S_DONE;
              end else begin
                cnt_q   <= cnt_q + 1'b1;
                mov_q   <= ent_in;
                pos_q   <= cnt_idx;
                state_q <= is_empty ? S_DONE : S_UP_CMP;
              end
            end else begin
              if (is_empty) begin
                res_status_q <= ST_EMPTY;
                state_q      <= S_DONE;
              end else begin
                cnt_q   <= cnt_q - 1'b1;
                state_q <= S_DN_ROOT;
              end
            end
          end
        end
        S_UP_CMP: begin
          if (up_less) begin
            pos_q   <= par;
            state_q <= (par == '0) ? S_PLACE : S_UP_CMP;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_DN_ROOT: begin
          res_key_q <= rd_a_q.key;
          res_pay_q <= rd_a_q.pay;
          mov_q     <= rd_b_q;
          pos_q     <= '0;
          state_q   <= (cnt_q > CNT_W'(1)) ? S_DN_CMP : S_DONE;
        end
        S_DN_CMP: begin
          if (dn_less) begin
            pos_q   <= c_idx;
            state_q <= (cl_w >= n_ext) ? S_PLACE : S_DN_CMP;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_PLACE: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid_o || !out_stall_i) begin
            out_valid_o   <= 1'b1;
            status_o      <= res_status_q;
            key_out_o     <= res_key_q;
            payload_out_o <= res_pay_q;
            count_o       <= COUNT_W'(cnt_q);
            state_q       <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import mhpq_pkg::*;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned PAY_W    = 8;
  localparam int unsigned STUCK_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned RANDOM_OPS  = 1400;

  typedef struct {
    func_e             func;
    logic [KEY_W-1:0]  key;
    logic [PAY_W-1:0]  payload;
    int unsigned       gap;
  } heap_op_t;

  typedef struct {
    status_e              status;
    logic [KEY_W-1:0]     key;
    logic [PAY_W-1:0]     payload;
    logic [COUNT_W-1:0]   count;
  } heap_outcome_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } heap_slot_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  func_e              func_i = FUNC_INSERT;
  logic [KEY_W-1:0]   key_i = '0;
  logic [PAY_W-1:0]   payload_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  status_e            status_o;
  logic [KEY_W-1:0]   key_out_o;
  logic [PAY_W-1:0]   payload_out_o;
  logic [COUNT_W-1:0] count_o;

  min_heap_priority_queue_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .key_i         (key_i),
    .payload_i     (payload_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .key_out_o     (key_out_o),
    .payload_out_o (payload_out_o),
    .count_o       (count_o)
  );

  always #2 clk_i = ~clk_i;

  // Shadow heap, updated as each input beat is accepted.
  heap_slot_t  heap_mem [CAPACITY];
  int unsigned heap_size = 0;

  heap_op_t      pending_ops [$];
  heap_outcome_t pending_outcomes [$];
  heap_op_t      cur_op;

  int unsigned gap_cnt = 0;
  int unsigned stall_cnt = 0;
  int unsigned hold;
  int unsigned stuck_cycles = 0;
  int unsigned bad_results = 0;
  int unsigned gen_size = 0;
  int unsigned random_ops = 0;
  bit          gen_calm = 1'b0;
  bit          out_calm = 1'b0;

  wire in_fire  = in_valid_i && !in_stall_o;
  wire out_fire = out_valid_o && !out_stall_i;

  function automatic void swap_slots(int unsigned a, int unsigned b);
    heap_slot_t t;
    t = heap_mem[a];
    heap_mem[a] = heap_mem[b];
    heap_mem[b] = t;
  endfunction

  function automatic heap_outcome_t apply_heap_op(heap_op_t op);
    heap_outcome_t res;
    int unsigned pos;
    int unsigned parent;
    int unsigned l;
    int unsigned r;
    int unsigned c;
    bit settled;
    res.status  = ST_OK;
    res.key     = '0;
    res.payload = '0;
    if (op.func == FUNC_INSERT) begin
      if (heap_size >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        pos = heap_size;
        heap_mem[pos] = '{key: op.key, payload: op.payload};
        settled = 1'b0;
        while (pos > 0 && !settled) begin
          parent = (pos - 1) / 2;
          if (heap_mem[pos].key < heap_mem[parent].key) begin
            swap_slots(pos, parent);
            pos = parent;
          end else begin
            settled = 1'b1;
          end
        end
        heap_size++;
      end
    end else begin
      if (heap_size == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.key     = heap_mem[0].key;
        res.payload = heap_mem[0].payload;
        heap_size--;
        heap_mem[0] = heap_mem[heap_size];
        // sift down; on equal children the left one wins
        pos = 0;
        settled = 1'b0;
        while (!settled) begin
          l = 2 * pos + 1;
          r = l + 1;
          if (l >= heap_size) begin
            settled = 1'b1;
          end else begin
            c = l;
            if (r < heap_size && heap_mem[r].key < heap_mem[l].key) c = r;
            if (heap_mem[c].key < heap_mem[pos].key) begin
              swap_slots(c, pos);
              pos = c;
            end else begin
              settled = 1'b1;
            end
          end
        end
      end
    end
    res.count = heap_size[COUNT_W-1:0];
    return res;
  endfunction

  function automatic int unsigned draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic logic [KEY_W-1:0] pick_key(int unsigned mode);
    case (mode)
      0: return $urandom_range(0, 15);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 15);
      2: return $urandom_range(0, 3) << (8 * $urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_op(func_e func, logic [KEY_W-1:0] key, logic [PAY_W-1:0] payload);
    heap_op_t op;
    if ($urandom_range(0, 39) == 0) gen_calm = !gen_calm;
    op.func    = func;
    op.key     = key;
    op.payload = payload;
    op.gap     = draw_wait(gen_calm);
    pending_ops.push_back(op);
    if (func == FUNC_INSERT && gen_size < CAPACITY) gen_size++;
    if (func == FUNC_EXTRACT && gen_size > 0) gen_size--;
  endtask

  // Driver: hold the beat while stalled, advance to the next after its gap.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_cnt <= 0;
    end else begin
      if (in_fire) pending_outcomes.push_back(apply_heap_op(cur_op));
      if (!in_valid_i || !in_stall_o) begin
        if (pending_ops.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (gap_cnt < pending_ops[0].gap) begin
          in_valid_i <= 1'b0;
          gap_cnt <= gap_cnt + 1;
        end else begin
          cur_op = pending_ops.pop_front();
          func_i <= cur_op.func;
          key_i <= cur_op.key;
          payload_i <= cur_op.payload;
          in_valid_i <= 1'b1;
          gap_cnt <= 0;
        end
      end
    end
  end

  // Monitor: check each result beat against the oldest outcome, then draw a stall.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_cnt <= 0;
    end else begin
      hold = stall_cnt;
      if (out_fire) begin
        if (pending_outcomes.size() == 0) begin
          bad_results++;
          if (bad_results <= 10)
            $display("%0t: unexpected result status=%0d key=%h payload=%h count=%0d",
                     $realtime, status_o, key_out_o, payload_out_o, count_o);
        end else begin
          heap_outcome_t exp;
          exp = pending_outcomes.pop_front();
          if (status_o !== exp.status || key_out_o !== exp.key ||
              payload_out_o !== exp.payload || count_o !== exp.count) begin
            bad_results++;
            if (bad_results <= 10)
              $display("%0t: mismatch exp status=%0d key=%h payload=%h count=%0d,",
                       $realtime, exp.status, exp.key, exp.payload, exp.count,
                       " got status=%0d key=%h payload=%h count=%0d",
                       status_o, key_out_o, payload_out_o, count_o);
          end
        end
        if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
        hold = draw_wait(out_calm);
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        stall_cnt <= hold - 1;
      end else begin
        out_stall_i <= 1'b0;
        stall_cnt <= 0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || in_fire || out_fire) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    int unsigned kind;
    int unsigned key_mode;
    int unsigned len;
    int unsigned pct;

    // Directed: empty extract, key extremes, ties on key, drain past empty.
    queue_op(FUNC_EXTRACT, 32'hFFFF_FFFF, 8'hFF);
    queue_op(FUNC_INSERT, 32'hFFFF_FFFF, 8'h00);
    queue_op(FUNC_INSERT, 32'h0000_0000, 8'hFF);
    queue_op(FUNC_INSERT, 32'h8000_0000, 8'h55);
    queue_op(FUNC_INSERT, 32'h7FFF_FFFF, 8'hAA);
    queue_op(FUNC_INSERT, 32'h8000_0000, 8'h01);
    queue_op(FUNC_INSERT, 32'h8000_0000, 8'h02);
    queue_op(FUNC_INSERT, 32'h0000_0000, 8'h80);
    repeat (7) queue_op(FUNC_EXTRACT, 32'h0000_0000, 8'h00);
    queue_op(FUNC_EXTRACT, 32'h5555_AAAA, 8'h5A);
    queue_op(FUNC_INSERT, 32'h0000_0001, 8'h7F);
    queue_op(FUNC_INSERT, 32'h0000_0001, 8'h03);
    queue_op(FUNC_INSERT, 32'h0000_0001, 8'h04);
    repeat (3) queue_op(FUNC_EXTRACT, 32'hAAAA_5555, 8'hA5);

    // Random: fill to full and beyond, drain past empty, and mixed runs.
    while (random_ops < RANDOM_OPS) begin
      kind = $urandom_range(0, 3);
      key_mode = $urandom_range(0, 4);
      case (kind)
        0: begin
          while (gen_size < CAPACITY) begin
            queue_op(FUNC_INSERT, pick_key(key_mode), PAY_W'($urandom));
            random_ops++;
          end
          repeat ($urandom_range(1, 3)) begin
            queue_op(FUNC_INSERT, pick_key(key_mode), PAY_W'($urandom));
            random_ops++;
          end
        end
        1: begin
          while (gen_size > 0) begin
            queue_op(FUNC_EXTRACT, $urandom, PAY_W'($urandom));
            random_ops++;
          end
          repeat ($urandom_range(1, 2)) begin
            queue_op(FUNC_EXTRACT, $urandom, PAY_W'($urandom));
            random_ops++;
          end
        end
        default: begin
          len = $urandom_range(20, 60);
          pct = (kind == 2) ? 60 : 40;
          repeat (len) begin
            if ($urandom_range(0, 99) < pct)
              queue_op(FUNC_INSERT, pick_key(key_mode), PAY_W'($urandom));
            else
              queue_op(FUNC_EXTRACT, $urandom, PAY_W'($urandom));
            random_ops++;
          end
        end
      endcase
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while ((pending_ops.size() != 0 || in_valid_i || pending_outcomes.size() != 0) &&
           stuck_cycles < STUCK_LIMIT)
      @(posedge clk_i);

    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("tb_top failed");
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk_i);
      if (bad_results == 0 && pending_outcomes.size() == 0)
        $display("tb_top passed");
      else
        $display("tb_top failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/mhpq_pkg.sv
rtl/min_heap_priority_queue_top.sv
tb/tb_top.sv
